// ===== rtl/amtspk_pkg.sv =====
// Shared types, token codes and slot layout for the spoken amount reader.
package amtspk_pkg;

    // Field widths and limits
    localparam int YUAN_W      = 27;
    localparam int CENTS_W     = 7;
    localparam int TOKEN_W     = 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;
    localparam logic [YUAN_W-1:0]  MAX_YUAN  = YUAN_W'(99999999);
    localparam logic [CENTS_W-1:0] MAX_CENTS = CENTS_W'(99);

    // Decimal conversion
    localparam int YUAN_DIGITS = 8;
    localparam int DIGITS_W    = YUAN_DIGITS * 4;
    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;  // 2^35 / 10, rounded up
    localparam int RECIP_SHIFT = 35;
    localparam int PROD_W      = YUAN_W + 32;

    // Token codes
    localparam logic [TOKEN_W-1:0] TOK_ZERO     = 4'd0;
    localparam logic [TOKEN_W-1:0] TOK_TEN      = 4'd10;
    localparam logic [TOKEN_W-1:0] TOK_HUNDRED  = 4'd11;
    localparam logic [TOKEN_W-1:0] TOK_THOUSAND = 4'd12;
    localparam logic [TOKEN_W-1:0] TOK_WAN      = 4'd13;
    localparam logic [TOKEN_W-1:0] TOK_POINT    = 4'd14;
    localparam logic [TOKEN_W-1:0] TOK_YUAN     = 4'd15;

    // Fixed reading slots; each amount enables a subset of them
    localparam int SLOT_YZERO = 0;   // lone zero for zero yuan
    localparam int SLOT_HI    = 1;   // seven slots of the wan group
    localparam int SLOT_WAN   = 8;
    localparam int SLOT_GAP   = 9;   // zero before a low group under 1000
    localparam int SLOT_LO    = 10;  // seven slots of the low group
    localparam int SLOT_POINT = 17;
    localparam int SLOT_CT    = 18;
    localparam int SLOT_CU    = 19;
    localparam int SLOT_YUAN  = 20;
    localparam int NUM_SLOTS  = 21;
    localparam int GROUP_SLOTS = 7;

    // Queue sizing
    localparam int QUEUE_DEPTH_DEF = 2;

    // One classified amount: enabled slots and the token of every slot
    typedef struct packed {
        logic [NUM_SLOTS-1:0]              mask;
        logic [NUM_SLOTS-1:0][TOKEN_W-1:0] tok;
    } t_plan;

endpackage

// ===== rtl/amount_to_spoken_numeral_tokens.sv =====
// Top level: reads a money amount as a stream of spoken Chinese numeral tokens.
//
// Input stream (s_axis): one amount per transaction, tdata[26:0] whole yuan,
// tdata[33:27] cents; values above 99999999 yuan or 99 cents clamp.
// Output stream (m_axis): one token per transaction in tdata[3:0]
// (0-9 digit, 10 ten, 11 hundred, 12 thousand, 13 wan, 14 point, 15 yuan),
// tlast on the closing yuan token. An all-zero amount yields no tokens.
// Throughput: tokens leave at one per cycle while m_axis_tready is high; the front
// works on one amount at a time (load, eight digits through the reciprocal multiplier,
// then the hand-off to the queue) but takes the next amount into its input register.
// The front holds one amount in its input register and the queue holds
// QUEUE_DEPTH classified amounts, so input is taken while tokens still drain.
// When the receiver stalls, the output register holds its token and the
// queue and front fill up before s_axis_tready drops.
// Reset (synchronous, active low) empties all stages; no clearing pass.
module amount_to_spoken_numeral_tokens
    import amtspk_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [26:0] yuan, [33:27] cents
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [3:0] token
    output logic                 m_axis_tlast
);

    logic  push_valid;
    logic  push_ready;
    t_plan push_plan;
    logic  pop_valid;
    logic  pop_ready;
    t_plan pop_plan;

    amtspk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_plan        (push_plan)
    );

    amtspk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_plan),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_plan)
    );

    amtspk_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_plan        (pop_plan),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/amtspk_front.sv =====
// Front end: input register, decimal digit loop and slot classification.
module amtspk_front
    import amtspk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output t_plan                o_plan
);

    localparam int CNT_W = $clog2(YUAN_DIGITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    // Slot enables of one four-digit group
    function automatic logic [GROUP_SLOTS-1:0] grp_mask(
        input logic [3:0] t, input logic [3:0] h, input logic [3:0] e, input logic [3:0] u);
        logic tn, hn, en, un;
        logic [GROUP_SLOTS-1:0] m;
        tn = (t != 4'd0);
        hn = (h != 4'd0);
        en = (e != 4'd0);
        un = (u != 4'd0);
        m[0] = tn;
        m[1] = tn;
        m[2] = (hn || en || un) && (hn || tn);
        m[3] = hn;
        m[4] = (en || un) && (en || hn);
        m[5] = en;
        m[6] = un;
        return m;
    endfunction

    logic                r_in_valid;
    logic [YUAN_W-1:0]   r_yuan;
    logic [CENTS_W-1:0]  r_cents;
    logic [1:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [YUAN_W-1:0]   r_val;
    logic [DIGITS_W-1:0] r_digs;
    logic [3:0]          r_ct;
    logic [3:0]          r_cu;
    logic                r_yz;
    logic                r_cz;

    logic                load;
    logic                nonempty;
    logic [YUAN_W-1:0]   yuan_c;
    logic [CENTS_W-1:0]  cents_c;
    logic [14:0]         cents_prod;
    logic [3:0]          ct;
    logic [CENTS_W-1:0]  cu_full;
    logic [PROD_W-1:0]   prod;
    logic [YUAN_W-1:0]   quo;
    logic [YUAN_W-1:0]   quo10;
    logic [YUAN_W-1:0]   rem_full;
    logic [GROUP_SLOTS-1:0] hi_m;
    logic [GROUP_SLOTS-1:0] lo_m;
    logic                hi_nz;
    logic                lo_nz;
    t_plan               plan;

    assign s_axis_tready = !r_in_valid;
    assign load          = (r_state == S_IDLE) && r_in_valid;
    assign nonempty      = !(r_yz && r_cz);
    assign o_push_valid  = (r_state == S_PUSH) && nonempty;
    assign o_plan        = plan;

    // Clamp the amount and split cents into two digits
    always_comb begin
        yuan_c     = (r_yuan > MAX_YUAN) ? MAX_YUAN : r_yuan;
        cents_c    = (r_cents > MAX_CENTS) ? MAX_CENTS : r_cents;
        cents_prod = 15'(cents_c) * 15'd205;
        ct         = cents_prod[14:11];
        cu_full    = cents_c - CENTS_W'({ct, 3'b000}) - CENTS_W'({ct, 1'b0});
    end

    // Peel off one decimal digit per cycle by reciprocal multiply
    always_comb begin
        prod     = PROD_W'(r_val) * PROD_W'(RECIP_TEN);
        quo      = YUAN_W'(prod[PROD_W-1:RECIP_SHIFT]);
        quo10    = YUAN_W'({quo, 3'b000}) + YUAN_W'({quo, 1'b0});
        rem_full = r_val - quo10;
    end

    // Hold input and advance the digit loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= S_IDLE;
            r_cnt      <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (load) begin
                        r_state <= S_CONV;
                        r_cnt   <= '0;
                    end
                end
                S_CONV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(YUAN_DIGITS - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!nonempty || i_push_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Capture payload and digits
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_yuan  <= s_axis_tdata[YUAN_W-1:0];
            r_cents <= s_axis_tdata[YUAN_W+CENTS_W-1:YUAN_W];
        end
        if (load) begin
            r_val <= yuan_c;
            r_yz  <= (yuan_c == '0);
            r_cz  <= (cents_c == '0);
            r_ct  <= ct;
            r_cu  <= cu_full[3:0];
        end else if (r_state == S_CONV) begin
            r_val  <= quo;
            r_digs <= {rem_full[3:0], r_digs[DIGITS_W-1:4]};
        end
    end

    // Classify the digits into enabled reading slots
    always_comb begin
        hi_nz = |r_digs[DIGITS_W-1:16];
        lo_nz = |r_digs[15:0];
        hi_m  = grp_mask(r_digs[31:28], r_digs[27:24], r_digs[23:20], r_digs[19:16]);
        lo_m  = grp_mask(r_digs[15:12], r_digs[11:8], r_digs[7:4], r_digs[3:0]);

        plan.mask = '0;
        plan.mask[SLOT_YZERO] = r_yz && !r_cz;
        plan.mask[SLOT_HI+GROUP_SLOTS-1:SLOT_HI] = hi_m;
        plan.mask[SLOT_WAN]   = hi_nz;
        plan.mask[SLOT_GAP]   = hi_nz && lo_nz && (r_digs[15:12] == 4'd0);
        plan.mask[SLOT_LO+GROUP_SLOTS-1:SLOT_LO] = lo_m;
        plan.mask[SLOT_POINT] = !r_cz;
        plan.mask[SLOT_CT]    = !r_cz;
        plan.mask[SLOT_CU]    = !r_cz;
        plan.mask[SLOT_YUAN]  = nonempty;

        plan.tok = '0;
        plan.tok[SLOT_YZERO] = TOK_ZERO;
        plan.tok[SLOT_HI+0]  = r_digs[31:28];
        plan.tok[SLOT_HI+1]  = TOK_THOUSAND;
        plan.tok[SLOT_HI+2]  = r_digs[27:24];
        plan.tok[SLOT_HI+3]  = TOK_HUNDRED;
        plan.tok[SLOT_HI+4]  = r_digs[23:20];
        plan.tok[SLOT_HI+5]  = TOK_TEN;
        plan.tok[SLOT_HI+6]  = r_digs[19:16];
        plan.tok[SLOT_WAN]   = TOK_WAN;
        plan.tok[SLOT_GAP]   = TOK_ZERO;
        plan.tok[SLOT_LO+0]  = r_digs[15:12];
        plan.tok[SLOT_LO+1]  = TOK_THOUSAND;
        plan.tok[SLOT_LO+2]  = r_digs[11:8];
        plan.tok[SLOT_LO+3]  = TOK_HUNDRED;
        plan.tok[SLOT_LO+4]  = r_digs[7:4];
        plan.tok[SLOT_LO+5]  = TOK_TEN;
        plan.tok[SLOT_LO+6]  = r_digs[3:0];
        plan.tok[SLOT_POINT] = TOK_POINT;
        plan.tok[SLOT_CT]    = r_ct;
        plan.tok[SLOT_CU]    = r_cu;
        plan.tok[SLOT_YUAN]  = TOK_YUAN;
    end

endmodule

// ===== rtl/amtspk_queue.sv =====
// Small queue of classified amounts between front and back ends.
module amtspk_queue
    import amtspk_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_plan i_push_data,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_plan o_pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_plan          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/amtspk_back.sv =====
// Back end: walks enabled slots and emits one token per cycle while the output is not stalled.
module amtspk_back
    import amtspk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pop_valid,
    output logic                 o_pop_ready,
    input  t_plan                i_plan,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast
);

    logic [NUM_SLOTS-1:0]              r_mask;
    logic [NUM_SLOTS-1:0][TOKEN_W-1:0] r_tok;
    logic                              r_out_valid;
    logic [TOKEN_W-1:0]                r_out_token;
    logic                              r_out_last;

    logic                 can_emit;
    logic                 have;
    logic [NUM_SLOTS-1:0] first;
    logic [NUM_SLOTS-1:0] rest;
    logic                 is_last;
    logic [TOKEN_W-1:0]   tok_sel;
    logic                 emit;

    // Pick the lowest enabled slot and its token
    always_comb begin
        can_emit = !r_out_valid || m_axis_tready;
        have     = (r_mask != '0);
        first    = r_mask & (~r_mask + NUM_SLOTS'(1));
        rest     = r_mask & ~first;
        is_last  = (rest == '0);
        tok_sel  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tok_sel |= first[i] ? r_tok[i] : '0;
        end
        emit        = can_emit && have;
        o_pop_ready = !have || (emit && is_last);
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_token);
    assign m_axis_tlast  = r_out_last;

    // Load the next amount, drop spent slots, drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop_ready && i_pop_valid) begin
                r_mask <= i_plan.mask;
            end else if (emit) begin
                r_mask <= rest;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (can_emit) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop_ready && i_pop_valid) begin
            r_tok <= i_plan.tok;
        end
        if (emit) begin
            r_out_token <= tok_sel;
            r_out_last  <= is_last;
        end
    end

endmodule

// ===== rtl/amtspk_checker.sv =====
// Port-level assertions on the output stream, bound to the top level.
module amtspk_checker
    import amtspk_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // Hold a stalled transaction
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // Yuan closes every reading and appears nowhere else
    a_yuan_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[TOKEN_W-1:0] == TOK_YUAN) == m_axis_tlast))
        else $error("yuan token and tlast disagree");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind amount_to_spoken_numeral_tokens amtspk_checker u_amtspk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
